### rtl/core/retransmit_ring_buffer_assert.svh
// ----------------------------------------------------------------------------
// Retransmit ring buffer assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RETRANSMIT_RING_BUFFER_ASSERT_SVH
`define RETRANSMIT_RING_BUFFER_ASSERT_SVH

// same-cycle implication, off during reset
`define RRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("retransmit ring buffer check failed");

// next-cycle implication, off during reset
`define RRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("retransmit ring buffer check failed");

`endif

### rtl/core/rrb_pkg.sv
// ----------------------------------------------------------------------------
// Retransmit ring buffer package
// Shared widths, operation codes and the status record.
// ----------------------------------------------------------------------------
package rrb_pkg;

    localparam int DEPTH_DEF  = 2048;
    localparam int CNT_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int OFFS_W     = 11;
    localparam int AMT_W      = 12;
    localparam int FUNC_W     = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE     = 2'd0,
        FUNC_READ      = 2'd1,
        FUNC_MARK_SENT = 2'd2,
        FUNC_ACK       = 2'd3
    } func_t;

    typedef struct packed {
        logic [CNT_W-1:0] done_count;
        logic [CNT_W-1:0] held_count;
        logic [CNT_W-1:0] unsent_count;
        logic [CNT_W-1:0] free_count;
        logic             byte_valid;
    } rrb_status_t;

endpackage

### rtl/core/rrb_store.sv
// ----------------------------------------------------------------------------
// Retransmit ring buffer byte store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module rrb_store #(
    parameter int DEPTH = rrb_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [rrb_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [rrb_pkg::BYTE_W-1:0] rd_data
);
    import rrb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data only moves on a read beat, so it holds while the result stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/rrb_ctrl.sv
// ----------------------------------------------------------------------------
// Retransmit ring buffer control
// Pointers, held/sent counts, clamps and the registered status record.
// ----------------------------------------------------------------------------
module rrb_ctrl #(
    parameter int DEPTH = rrb_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        op_valid,
    input  rrb_pkg::func_t              func,
    input  logic [rrb_pkg::BYTE_W-1:0]  data_byte,
    input  logic [rrb_pkg::OFFS_W-1:0]  offset,
    input  logic [rrb_pkg::AMT_W-1:0]   amount,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [rrb_pkg::BYTE_W-1:0]  wr_data,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    output rrb_pkg::rrb_status_t        status
);
    import rrb_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int MW    = (CW > AMT_W) ? CW : AMT_W;
    localparam int SW    = MW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] sent_reg, sent_next;
    rrb_status_t   status_reg, status_next;

    logic [SW-1:0] held_ext, sent_ext, unsent_ext, amt_ext;
    logic [SW-1:0] mark_clamp, ack_clamp, done;
    logic [SW-1:0] rd_sum, ack_sum;
    logic          valid;

    always_comb begin
        held_ext   = SW'(held_reg);
        sent_ext   = SW'(sent_reg);
        unsent_ext = SW'(held_reg - sent_reg);
        amt_ext    = SW'(amount);
        mark_clamp = (amt_ext > unsent_ext) ? unsent_ext : amt_ext;
        ack_clamp  = (amt_ext > sent_ext) ? sent_ext : amt_ext;

        // head + offset stays below 2*DEPTH whenever the read is in range
        rd_sum  = SW'(head_reg) + SW'(offset);
        rd_addr = (rd_sum >= DEPTH_S) ? AW'(rd_sum - DEPTH_S) : AW'(rd_sum);
        ack_sum = SW'(head_reg) + ack_clamp;

        head_next = head_reg;
        tail_next = tail_reg;
        held_next = held_reg;
        sent_next = sent_reg;
        done      = '0;
        valid     = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;

        unique case (func)
            FUNC_WRITE: begin
                if (held_ext < DEPTH_S) begin
                    wr_en     = op_valid;
                    tail_next = (tail_reg == LAST_A) ? '0 : tail_reg + AW'(1);
                    held_next = held_reg + CW'(1);
                    done      = SW'(1);
                end
            end
            FUNC_READ: begin
                rd_en = op_valid;
                if (SW'(offset) < held_ext) begin
                    valid = 1'b1;
                    done  = SW'(1);
                end
            end
            FUNC_MARK_SENT: begin
                done      = mark_clamp;
                sent_next = sent_reg + CW'(mark_clamp);
            end
            FUNC_ACK: begin
                done      = ack_clamp;
                head_next = (ack_sum >= DEPTH_S) ? AW'(ack_sum - DEPTH_S) : AW'(ack_sum);
                held_next = held_reg - CW'(ack_clamp);
                sent_next = sent_reg - CW'(ack_clamp);
            end
            default: begin
            end
        endcase

        status_next.done_count   = CNT_W'(done);
        status_next.held_count   = CNT_W'(held_next);
        status_next.unsent_count = CNT_W'(held_next - sent_next);
        status_next.free_count   = CNT_W'(DEPTH_C - held_next);
        status_next.byte_valid   = valid;
    end

    assign wr_addr = tail_reg;
    assign wr_data = data_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            held_reg <= '0;
            sent_reg <= '0;
        end else if (op_valid) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            held_reg <= held_next;
            sent_reg <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op_valid) begin
            status_reg <= status_next;
        end
    end

    assign status = status_reg;

endmodule

### rtl/core/retransmit_ring_buffer.sv
// ----------------------------------------------------------------------------
// Retransmit ring buffer
// Byte ring for a TCP send path: write, read at offset, mark sent, acknowledge.
// ----------------------------------------------------------------------------
// Result path: one register stage between input beat and result beat.
// Throughput: one item per cycle unless the result stream stalls; pointers,
//   clamps and the single store access all finish in the cycle the beat is taken.
// Reset: pointers, counts and the result valid clear; store contents are
//   left undefined, no clearing pass; unwritten bytes are masked by byte_valid.
module retransmit_ring_buffer #(
    parameter int DEPTH = rrb_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] data_byte, [18:8] offset, [30:19] amount, [31] zero
    input  logic [rrb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] func
    input  logic [rrb_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [11:0] done_count, [19:12] byte_out, [20] byte_valid, [32:21] held_count,
    // [44:33] unsent_count, [56:45] free_count, [63:57] zero
    output logic [rrb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rrb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              accept;
    logic              m_tvalid_reg, m_tvalid_next;
    func_t             func;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data, byte_out;
    rrb_status_t       status;

    assign s_axis_tready = !m_tvalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign func          = func_t'(s_axis_tuser);

    rrb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (accept),
        .func      (func),
        .data_byte (s_axis_tdata[7:0]),
        .offset    (s_axis_tdata[18:8]),
        .amount    (s_axis_tdata[30:19]),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .status    (status)
    );

    rrb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // stale read data is masked unless this beat was an in-range read
    assign byte_out      = status.byte_valid ? rd_data : '0;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {7'b0, status.free_count, status.unsent_count,
                            status.held_count, status.byte_valid, byte_out,
                            status.done_count};

endmodule

### rtl/core/rrb_checker.sv
// ----------------------------------------------------------------------------
// Retransmit ring buffer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "retransmit_ring_buffer_assert.svh"

module rrb_checker #(
    parameter int DEPTH = rrb_pkg::DEPTH_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rrb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rrb_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_M = CNT_W'(DEPTH);

    logic [BYTE_W-1:0] byte_out;
    logic              byte_valid;
    logic [CNT_W-1:0]  held, unsent, free_cnt;
    logic [CNT_W:0]    count_sum;

    assign byte_out   = m_axis_tdata[19:12];
    assign byte_valid = m_axis_tdata[20];
    assign held       = m_axis_tdata[32:21];
    assign unsent     = m_axis_tdata[44:33];
    assign free_cnt   = m_axis_tdata[56:45];
    assign count_sum  = {1'b0, held} + {1'b0, free_cnt};

    `RRB_ASSERT_NXT(a_hold_stall, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `RRB_ASSERT_NXT(a_beat_yields_result, aclk, aresetn, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `RRB_ASSERT_IMP(a_held_plus_free, aclk, aresetn, m_axis_tvalid, count_sum[CNT_W-1:0] == DEPTH_M)
    `RRB_ASSERT_IMP(a_unsent_in_held, aclk, aresetn, m_axis_tvalid, (DEPTH > 4095) || (unsent <= held))
    `RRB_ASSERT_IMP(a_invalid_byte_zero, aclk, aresetn, m_axis_tvalid && !byte_valid, byte_out == '0)

endmodule

bind retransmit_ring_buffer rrb_checker #(
    .DEPTH (DEPTH)
) u_rrb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
